// ----- sv/tnc_pkg.sv -----
// ----------------------------------------------------------------------------
// tnc_pkg
// shared widths, codes and defaults of the face normal and centroid engine
// ----------------------------------------------------------------------------
package tnc_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int COORD_BITS_DEF   = 24;

    localparam int COORD_W  = 24;
    localparam int VADDR_W  = 12;
    localparam int CORNER_W = 13;
    localparam int NRM_W    = 52;
    localparam int CEN_W    = 24;
    localparam int THR_W    = 16;
    localparam int SQ_W     = 106;
    localparam int ROOT_W   = 53;
    localparam int DIV_W    = 54;
    localparam int Q_W      = 15;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic CMD_VERTEX   = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    localparam logic CFG_NORMALIZE = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

endpackage

// ----- sv/triangle_normal_centroid.sv -----
// path: the memory read, the queue, then 76 back stages (6 arithmetic, 54 square root,
// 15 division, output); the back pipeline advances whenever the output is free
// throughput: one item per cycle while the queue has room and the output is free
// reset: synchronous active low, clears control state; normalize 1, threshold 1;
// the vertex memory is not cleared and holds no data until written
// ----------------------------------------------------------------------------
// triangle_normal_centroid
// face normal and centroid engine over a vertex memory
// ----------------------------------------------------------------------------
module triangle_normal_centroid #(
    parameter int VERTEX_DEPTH = tnc_pkg::VERTEX_DEPTH_DEF,
    parameter int COORD_BITS   = tnc_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_index,
    input  logic [tnc_pkg::THR_W-1:0]        i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_cmd,
    input  logic [tnc_pkg::VADDR_W-1:0]      i_vertex_addr,
    input  logic signed [tnc_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tnc_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tnc_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tnc_pkg::CORNER_W-1:0]     i_corner_a,
    input  logic [tnc_pkg::CORNER_W-1:0]     i_corner_b,
    input  logic [tnc_pkg::CORNER_W-1:0]     i_corner_c,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [tnc_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [tnc_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [tnc_pkg::NRM_W-1:0] o_normal_z,
    output logic signed [tnc_pkg::CEN_W-1:0] o_center_x,
    output logic signed [tnc_pkg::CEN_W-1:0] o_center_y,
    output logic signed [tnc_pkg::CEN_W-1:0] o_center_z,
    output logic                             o_degenerate,
    output logic                             o_index_error
);
    import tnc_pkg::*;

    localparam int FW = 9 * COORD_BITS + 1;

    logic             r_normalize;
    logic [THR_W-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normalize <= 1'b1;
            r_threshold <= THR_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NORMALIZE: r_normalize <= i_cfg_data[0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    logic               push, pop, fifo_valid;
    logic [FW-1:0]      push_data, fifo_data;
    logic [FIFO_CW-1:0] fifo_count;

    tnc_front #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_vertex_addr (i_vertex_addr),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_corner_a    (i_corner_a),
        .i_corner_b    (i_corner_b),
        .i_corner_c    (i_corner_c),
        .i_fifo_count  (fifo_count),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    tnc_fifo #(
        .W     (FW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    tnc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_valid  (fifo_valid),
        .i_fifo_data   (fifo_data),
        .o_fifo_pop    (pop),
        .i_normalize   (r_normalize),
        .i_threshold   (r_threshold),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_center_z    (o_center_z),
        .o_degenerate  (o_degenerate),
        .o_index_error (o_index_error)
    );
endmodule

// ----- sv/tnc_fifo.sv -----
// ----------------------------------------------------------------------------
// tnc_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module tnc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [W-1:0]               o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (32'(r_wptr) == DEPTH - 1) ? '0 : r_wptr + PW'(1);
            end
            if (pop_ok) begin
                r_rptr <= (32'(r_rptr) == DEPTH - 1) ? '0 : r_rptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop_ok);
        end
    end
endmodule

// ----- sv/tnc_front.sv -----
// ----------------------------------------------------------------------------
// tnc_front
// accepts items, keeps the vertex memory, reads triangle corners into the queue
// ----------------------------------------------------------------------------
module tnc_front #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_BITS   = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_cmd,
    input  logic [tnc_pkg::VADDR_W-1:0]        i_vertex_addr,
    input  logic signed [tnc_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tnc_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tnc_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tnc_pkg::CORNER_W-1:0]       i_corner_a,
    input  logic [tnc_pkg::CORNER_W-1:0]       i_corner_b,
    input  logic [tnc_pkg::CORNER_W-1:0]       i_corner_c,
    input  logic [tnc_pkg::FIFO_CW-1:0]        i_fifo_count,
    output logic                               o_push,
    output logic [9*COORD_BITS:0]              o_push_data
);
    import tnc_pkg::*;

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int VW = 3 * COORD_BITS;

    logic [VW-1:0] mem_a [VERTEX_DEPTH];
    logic [VW-1:0] mem_b [VERTEX_DEPTH];
    logic [VW-1:0] mem_c [VERTEX_DEPTH];

    logic [VW-1:0] r_rd_a, r_rd_b, r_rd_c;
    logic          r_s1_valid, r_s1_err;

    logic          accept, wr_ok, err;
    logic [AW-1:0] wr_addr, addr_a, addr_b, addr_c;
    logic [VW-1:0] wr_data;

    assign o_ready = (32'(i_fifo_count) + 32'(r_s1_valid)) < FIFO_DEPTH;
    assign accept  = i_valid && o_ready;

    assign wr_addr = AW'(32'(i_vertex_addr));
    assign wr_ok   = accept && (i_cmd == CMD_VERTEX) && (32'(i_vertex_addr) < VERTEX_DEPTH);
    assign wr_data = {COORD_BITS'($unsigned(i_coord_z)), COORD_BITS'($unsigned(i_coord_y)),
                      COORD_BITS'($unsigned(i_coord_x))};

    assign addr_a = AW'(32'(i_corner_a) - 32'd1);
    assign addr_b = AW'(32'(i_corner_b) - 32'd1);
    assign addr_c = AW'(32'(i_corner_c) - 32'd1);

    assign err = (i_corner_a == '0) || (32'(i_corner_a) > VERTEX_DEPTH)
              || (i_corner_b == '0) || (32'(i_corner_b) > VERTEX_DEPTH)
              || (i_corner_c == '0) || (32'(i_corner_c) > VERTEX_DEPTH);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
            mem_c[wr_addr] <= wr_data;
        end
        if (accept && (i_cmd == CMD_TRIANGLE)) begin
            r_rd_a   <= mem_a[addr_a];
            r_rd_b   <= mem_b[addr_b];
            r_rd_c   <= mem_c[addr_c];
            r_s1_err <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && (i_cmd == CMD_TRIANGLE);
        end
    end

    assign o_push      = r_s1_valid;
    assign o_push_data = {r_s1_err, r_rd_c, r_rd_b, r_rd_a};
endmodule

// ----- sv/tnc_isqrt.sv -----
// ----------------------------------------------------------------------------
// tnc_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module tnc_isqrt #(
    parameter int SW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [tnc_pkg::SQ_W-1:0]    i_num,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [tnc_pkg::ROOT_W-1:0]  o_root,
    output logic [SW-1:0]               o_side
);
    import tnc_pkg::*;

    localparam int NS = ROOT_W;
    localparam int RW = ROOT_W + 3;

    logic [SQ_W-1:0]   r_num  [0:NS];
    logic [RW-1:0]     r_rem  [0:NS];
    logic [ROOT_W-1:0] r_root [0:NS];
    logic [SW-1:0]     r_side [0:NS];
    logic              r_v    [0:NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= i_num;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RW-1:0] remn, trial;
        assign remn  = {r_rem[s][RW-3:0], r_num[s][SQ_W-1 -: 2]};
        assign trial = {1'b0, r_root[s], 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1]  <= {r_num[s][SQ_W-3:0], 2'b00};
                r_side[s+1] <= r_side[s];
                if (remn >= trial) begin
                    r_rem[s+1]  <= remn - trial;
                    r_root[s+1] <= {r_root[s][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1]  <= remn;
                    r_root[s+1] <= {r_root[s][ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_root  = r_root[NS];
    assign o_side  = r_side[NS];
endmodule

// ----- sv/tnc_back.sv -----
// ----------------------------------------------------------------------------
// tnc_back
// cross product, centroid, length, unit scaling and the output register
// ----------------------------------------------------------------------------
module tnc_back #(
    parameter int COORD_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fifo_valid,
    input  logic [9*COORD_BITS:0]            i_fifo_data,
    output logic                             o_fifo_pop,
    input  logic                             i_normalize,
    input  logic [tnc_pkg::THR_W-1:0]        i_threshold,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [tnc_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [tnc_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [tnc_pkg::NRM_W-1:0] o_normal_z,
    output logic signed [tnc_pkg::CEN_W-1:0] o_center_x,
    output logic signed [tnc_pkg::CEN_W-1:0] o_center_y,
    output logic signed [tnc_pkg::CEN_W-1:0] o_center_z,
    output logic                             o_degenerate,
    output logic                             o_index_error
);
    import tnc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int D    = CB + 1;
    localparam int PW   = (2 * D > NRM_W) ? 2 * D + 1 : NRM_W + 1;
    localparam int CS   = CB + 2;
    localparam logic [63:0] CM64 = (64'd1 << CS) / 64'd3;
    localparam logic [CB:0] CM   = CM64[CB:0];
    localparam int SW   = 3 * NRM_W + 3 * CEN_W + 2;
    localparam int NDIV = Q_W;
    localparam int HW   = NRM_W / 2;

    logic en;
    assign en         = !o_valid || i_ready;
    assign o_fifo_pop = en && i_fifo_valid;

    // stage a: edges and coordinate sums
    logic signed [CB-1:0] pc [3][3];
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        for (genvar k = 0; k < 3; k++) begin : g_ax
            assign pc[i][k] = i_fifo_data[(3*i+k)*CB +: CB];
        end
    end

    logic signed [D-1:0]    r_a_e1 [3];
    logic signed [D-1:0]    r_a_e2 [3];
    logic signed [CB+1:0]   r_a_sum [3];
    logic                   r_a_err, r_a_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_e1[k]  <= D'(pc[0][k]) - D'(pc[1][k]);
                r_a_e2[k]  <= D'(pc[0][k]) - D'(pc[2][k]);
                r_a_sum[k] <= (CB+2)'(pc[0][k]) + (CB+2)'(pc[1][k]) + (CB+2)'(pc[2][k]);
            end
            r_a_err <= i_fifo_data[9*CB];
        end
    end

    // stage b: products
    logic signed [2*D-1:0] r_b_p [6];
    logic                  r_b_neg [3];
    logic [CB:0]           r_b_m [3];
    logic [2*CB+1:0]       r_b_cp [3];
    logic                  r_b_err, r_b_v;
    logic [CB:0]           cm_abs [3];

    for (genvar k = 0; k < 3; k++) begin : g_abs
        assign cm_abs[k] = r_a_sum[k][CB+1] ? (CB+1)'(-r_a_sum[k]) : (CB+1)'(r_a_sum[k]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_p[0] <= r_a_e1[1] * r_a_e2[2];
            r_b_p[1] <= r_a_e1[2] * r_a_e2[1];
            r_b_p[2] <= r_a_e1[2] * r_a_e2[0];
            r_b_p[3] <= r_a_e1[0] * r_a_e2[2];
            r_b_p[4] <= r_a_e1[0] * r_a_e2[1];
            r_b_p[5] <= r_a_e1[1] * r_a_e2[0];
            for (int k = 0; k < 3; k++) begin
                r_b_neg[k] <= r_a_sum[k][CB+1];
                r_b_m[k]   <= cm_abs[k];
                r_b_cp[k]  <= cm_abs[k] * CM;
            end
            r_b_err <= r_a_err;
        end
    end

    // stage c: raw normal and centroid correction
    logic [NRM_W-1:0] r_c_raw [3];
    logic [CEN_W-1:0] r_c_cen [3];
    logic             r_c_err, r_c_v;
    logic signed [PW-1:0] cdiff [3];
    logic [CB-1:0]        q0 [3];
    logic [CB+2:0]        crem [3];
    logic [CB-1:0]        q1 [3];
    logic signed [CB:0]   qs [3];

    for (genvar k = 0; k < 3; k++) begin : g_c
        assign cdiff[k] = PW'(r_b_p[2*k]) - PW'(r_b_p[2*k+1]);
        assign q0[k]    = CB'(r_b_cp[k] >> CS);
        assign crem[k]  = (CB+3)'(r_b_m[k]) - (CB+3)'(q0[k]) * (CB+3)'(3);
        assign q1[k]    = (crem[k] >= (CB+3)'(3)) ? q0[k] + CB'(1) : q0[k];
        assign qs[k]    = r_b_neg[k] ? -$signed({1'b0, q1[k]}) : $signed({1'b0, q1[k]});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_c_raw[k] <= cdiff[k][NRM_W-1:0];
                r_c_cen[k] <= CEN_W'(64'(qs[k]));
            end
            r_c_err <= r_b_err;
        end
    end

    // stage d: magnitude halves squared
    logic [2*HW-1:0]  r_d_hh [3];
    logic [2*HW-1:0]  r_d_hl [3];
    logic [2*HW-1:0]  r_d_ll [3];
    logic [NRM_W-1:0] r_d_raw [3];
    logic [CEN_W-1:0] r_d_cen [3];
    logic             r_d_err, r_d_v;
    logic [NRM_W-1:0] dmag [3];

    for (genvar k = 0; k < 3; k++) begin : g_d
        assign dmag[k] = r_c_raw[k][NRM_W-1] ? NRM_W'(0) - r_c_raw[k] : r_c_raw[k];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_d_hh[k]  <= dmag[k][NRM_W-1:HW] * dmag[k][NRM_W-1:HW];
                r_d_hl[k]  <= dmag[k][NRM_W-1:HW] * dmag[k][HW-1:0];
                r_d_ll[k]  <= dmag[k][HW-1:0] * dmag[k][HW-1:0];
                r_d_raw[k] <= r_c_raw[k];
                r_d_cen[k] <= r_c_cen[k];
            end
            r_d_err <= r_c_err;
        end
    end

    // stage e: squares
    logic [SQ_W-1:0]  r_e_sq [3];
    logic [NRM_W-1:0] r_e_raw [3];
    logic [CEN_W-1:0] r_e_cen [3];
    logic             r_e_err, r_e_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e_sq[k]  <= (SQ_W'(r_d_hh[k]) << (2*HW)) + (SQ_W'(r_d_hl[k]) << (HW+1))
                            + SQ_W'(r_d_ll[k]);
                r_e_raw[k] <= r_d_raw[k];
                r_e_cen[k] <= r_d_cen[k];
            end
            r_e_err <= r_d_err;
        end
    end

    // stage f: length squared and degenerate test
    logic [SQ_W-1:0]  r_f_s;
    logic [NRM_W-1:0] r_f_raw [3];
    logic [CEN_W-1:0] r_f_cen [3];
    logic             r_f_degen, r_f_err, r_f_v;
    logic [SQ_W-1:0]  ssum;
    logic [2*THR_W-1:0] thr_sq;

    assign ssum   = r_e_sq[0] + r_e_sq[1] + r_e_sq[2];
    assign thr_sq = i_threshold * i_threshold;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_s     <= ssum;
            r_f_degen <= (ssum == '0) || (ssum < SQ_W'(thr_sq));
            for (int k = 0; k < 3; k++) begin
                r_f_raw[k] <= r_e_raw[k];
                r_f_cen[k] <= r_e_cen[k];
            end
            r_f_err <= r_e_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_fifo_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    // square root
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [SW-1:0]     sq_side, f_side;

    assign f_side = {r_f_err, r_f_degen, r_f_cen[2], r_f_cen[1], r_f_cen[0],
                     r_f_raw[2], r_f_raw[1], r_f_raw[0]};

    tnc_isqrt #(
        .SW (SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   (r_f_s),
        .i_side  (f_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // unit scaling: restoring division, one quotient bit per stage
    logic [DIV_W-1:0]  r_dr   [0:NDIV-1][3];
    logic [Q_W-1:0]    r_dq   [0:NDIV-1][3];
    logic [ROOT_W-1:0] r_dlen [0:NDIV-1];
    logic [SW-1:0]     r_dside[0:NDIV-1];
    logic              r_dv   [0:NDIV-1];
    logic [NRM_W-1:0]  smag [3];

    for (genvar k = 0; k < 3; k++) begin : g_smag
        logic [NRM_W-1:0] sraw;
        assign sraw    = sq_side[k*NRM_W +: NRM_W];
        assign smag[k] = sraw[NRM_W-1] ? NRM_W'(0) - sraw : sraw;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (DIV_W'(smag[k]) >= DIV_W'(sq_root)) begin
                    r_dr[0][k] <= DIV_W'(smag[k]) - DIV_W'(sq_root);
                    r_dq[0][k] <= Q_W'(1);
                end else begin
                    r_dr[0][k] <= DIV_W'(smag[k]);
                    r_dq[0][k] <= '0;
                end
            end
            r_dlen[0]  <= sq_root;
            r_dside[0] <= sq_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= sq_v;
        end
    end

    for (genvar s = 1; s < NDIV; s++) begin : g_div
        logic [DIV_W-1:0] r2 [3];
        for (genvar k = 0; k < 3; k++) begin : g_lane
            assign r2[k] = {r_dr[s-1][k][DIV_W-2:0], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    if (r2[k] >= DIV_W'(r_dlen[s-1])) begin
                        r_dr[s][k] <= r2[k] - DIV_W'(r_dlen[s-1]);
                        r_dq[s][k] <= {r_dq[s-1][k][Q_W-2:0], 1'b1};
                    end else begin
                        r_dr[s][k] <= r2[k];
                        r_dq[s][k] <= {r_dq[s-1][k][Q_W-2:0], 1'b0};
                    end
                end
                r_dlen[s]  <= r_dlen[s-1];
                r_dside[s] <= r_dside[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (en) begin
                r_dv[s] <= r_dv[s-1];
            end
        end
    end

    // output register
    logic [SW-1:0]    lside;
    logic             l_err, l_degen;
    logic [NRM_W-1:0] l_nrm [3];

    assign lside   = r_dside[NDIV-1];
    assign l_err   = lside[SW-1];
    assign l_degen = lside[SW-2];

    for (genvar k = 0; k < 3; k++) begin : g_out
        logic [NRM_W-1:0] lraw, qext;
        assign lraw = lside[k*NRM_W +: NRM_W];
        assign qext = NRM_W'(r_dq[NDIV-1][k]);
        always_comb begin
            if (l_err) begin
                l_nrm[k] = '0;
            end else if (i_normalize && !l_degen) begin
                l_nrm[k] = lraw[NRM_W-1] ? NRM_W'(0) - qext : qext;
            end else begin
                l_nrm[k] = lraw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_normal_x    <= l_nrm[0];
            o_normal_y    <= l_nrm[1];
            o_normal_z    <= l_nrm[2];
            o_center_x    <= l_err ? '0 : lside[3*NRM_W +: CEN_W];
            o_center_y    <= l_err ? '0 : lside[3*NRM_W+CEN_W +: CEN_W];
            o_center_z    <= l_err ? '0 : lside[3*NRM_W+2*CEN_W +: CEN_W];
            o_degenerate  <= l_err ? 1'b0 : l_degen;
            o_index_error <= l_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dv[NDIV-1];
        end
    end
endmodule
